@@ rtl/ctsyn_pkg.sv @@
// Package for the chord tone synthesiser: widths, codes, pitch and sine tables.
// No dependencies; imported by every module of the block.
`default_nettype none
package ctsyn_pkg;

    localparam int CHANNELS_DEF        = 2;
    localparam int VOICES_DEF          = 4;
    localparam int SINE_TABLE_BITS_DEF = 8;

    localparam int NOTE_FIELDS = 4;
    localparam int NOTE_W      = 7;
    localparam int NOTE_CODES  = 108;
    localparam int PITCH_W     = 21;
    localparam int RATE_W      = 36;
    localparam int RATE_HALF   = 18;
    localparam int PHASE_W     = 32;
    localparam int WAVE_W      = 16;
    localparam int SUM_W       = 20;
    localparam int VOL_W       = 9;
    localparam int SAMPLE_W    = 16;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 16;

    localparam logic [RATE_W-1:0] RATE_RESET = 36'd6382652534;
    localparam logic [VOL_W-1:0]  VOL_FULL   = 9'd256;
    localparam logic [NOTE_W-1:0] NOTE_REST  = 7'd127;
    localparam int Q14_ONE = 16384;

    localparam logic [1:0] WF_SINE     = 2'd0;
    localparam logic [1:0] WF_TRIANGLE = 2'd1;
    localparam logic [1:0] WF_SQUARE   = 2'd2;
    localparam logic [1:0] WF_SAW      = 2'd3;

    typedef logic [NOTE_W-1:0] t_note;

    // Top octave, C8 to B8, in Q8 Hz
    function automatic logic [PITCH_W-1:0] top_octave(input logic [3:0] semi);
        logic [PITCH_W-1:0] v;
        case (semi)
            4'd0:    v = 21'd1071618;
            4'd1:    v = 21'd1135340;
            4'd2:    v = 21'd1202851;
            4'd3:    v = 21'd1274376;
            4'd4:    v = 21'd1350154;
            4'd5:    v = 21'd1430439;
            4'd6:    v = 21'd1515497;
            4'd7:    v = 21'd1605613;
            4'd8:    v = 21'd1701088;
            4'd9:    v = 21'd1802240;
            4'd10:   v = 21'd1909407;
            4'd11:   v = 21'd2022946;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [PITCH_W-1:0] note_pitch(input t_note code);
        logic [3:0]          oct;
        logic [NOTE_W-1:0]   semi;
        logic [3:0]          sh;
        logic [PITCH_W:0]    v;
        oct = '0;
        for (int o = 1; o < 9; o++) begin
            if (code >= NOTE_W'(12 * o)) oct = 4'(o);
        end
        semi = code - NOTE_W'(12 * oct);
        sh   = 4'd8 - oct;
        v    = {1'b0, top_octave(semi[3:0])};
        if (sh != 4'd0) v = (v + ((PITCH_W+1)'(1) << (sh - 4'd1))) >> sh;
        if (code >= NOTE_W'(NOTE_CODES)) v = '0;
        return v[PITCH_W-1:0];
    endfunction

    // sin(pi/2 * t), t in Q16, result Q14
    function automatic longint unsigned quarter_sine(input longint unsigned t);
        longint unsigned tt;
        longint unsigned a;
        longint unsigned r;
        tt = (t * t) >> 16;
        a  = 64'd5026995 - ((tt * 64'd172271) >> 16);
        a  = 64'd85569306 - ((tt * a) >> 16);
        a  = 64'd693598668 - ((tt * a) >> 16);
        a  = 64'd1686629713 - ((tt * a) >> 16);
        r  = (t * a + (64'd1 << 31)) >> 32;
        if (r > 64'd16384) r = 64'd16384;
        return r;
    endfunction

    function automatic logic signed [WAVE_W-1:0] sine_entry(input int k, input int bits);
        int              qbits;
        int              quarter;
        int              q;
        longint unsigned t;
        longint unsigned v;
        qbits   = bits - 2;
        quarter = 1 << qbits;
        q       = k >> qbits;
        t       = longint'((k & (quarter - 1)) << (16 - qbits));
        if ((q & 1) != 0) t = 64'd65536 - t;
        v = quarter_sine(t);
        if ((q & 2) != 0) return -WAVE_W'(v);
        return WAVE_W'(v);
    endfunction

endpackage
`default_nettype wire

@@ rtl/ctsyn_phase_mem.sv @@
// Voice phase store: synchronous RAM with registered read, per-entry valid bits.
// Depends on ctsyn_pkg.
`default_nettype none
module ctsyn_phase_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rd_en,
    input  wire logic [AW-1:0]                i_rd_addr,
    output logic [ctsyn_pkg::PHASE_W-1:0]     o_rd_data,
    input  wire logic                         i_wr_en,
    input  wire logic [AW-1:0]                i_wr_addr,
    input  wire logic [ctsyn_pkg::PHASE_W-1:0] i_wr_data
);
    import ctsyn_pkg::*;

    logic [PHASE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    logic [PHASE_W-1:0] r_rd;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en) r_rd <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) r_valid[i_wr_addr] <= 1'b1;
            if (i_rd_en) r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // unwritten entries read as zero
    assign o_rd_data = r_rd_valid ? r_rd : '0;
endmodule
`default_nettype wire

@@ rtl/ctsyn_wave.sv @@
// Waveform shaper: sine from a constant table, triangle, square and sawtooth from a phase.
// Depends on ctsyn_pkg.
`default_nettype none
module ctsyn_wave #(
    parameter int SINE_TABLE_BITS = 8
) (
    input  wire logic [1:0]                          i_form,
    input  wire logic [ctsyn_pkg::PHASE_W-1:0]       i_phase,
    output logic signed [ctsyn_pkg::WAVE_W-1:0]      o_wave
);
    import ctsyn_pkg::*;

    localparam int SINE_LEN = 1 << SINE_TABLE_BITS;

    logic signed [WAVE_W-1:0] w_sine [SINE_LEN];
    logic [15:0]              w_u;
    logic signed [WAVE_W-1:0] w_tri;
    logic signed [WAVE_W-1:0] w_sq;
    logic signed [WAVE_W-1:0] w_saw;

    for (genvar k = 0; k < SINE_LEN; k++) begin : g_sine
        assign w_sine[k] = sine_entry(k, SINE_TABLE_BITS);
    end

    assign w_u = i_phase[31:16];

    always_comb begin
        if (w_u < 16'd16384)      w_tri = WAVE_W'(w_u);
        else if (w_u < 16'd49152) w_tri = WAVE_W'(17'd32768 - {1'b0, w_u});
        else                      w_tri = WAVE_W'(w_u);
        if (i_phase[30:0] == '0)  w_sq = '0;
        else if (!i_phase[31])    w_sq = WAVE_W'(Q14_ONE);
        else                      w_sq = -WAVE_W'(Q14_ONE);
        w_saw = {i_phase[31], i_phase[31:17]};
    end

    always_comb begin
        case (i_form)
            WF_SINE:     o_wave = w_sine[i_phase[PHASE_W-1 -: SINE_TABLE_BITS]];
            WF_TRIANGLE: o_wave = w_tri;
            WF_SQUARE:   o_wave = w_sq;
            WF_SAW:      o_wave = w_saw;
            default:     o_wave = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/chord_tone_synthesizer.sv @@
// Chord tone synthesiser top level: voice sequencer, phase update, mixer, output register.
// Depends on ctsyn_pkg, ctsyn_phase_mem and ctsyn_wave.
//
// Usage:
//   Slave stream: one transaction is one sample request. tuser carries the channel;
//   tdata carries restart, waveform, volume and four note codes.
//   Master stream: one transaction per request, tdata the clamped int16 sample,
//   tuser the channel echoed.
//   Configuration: i_cfg_we writes i_cfg_wdata to rate_scale; write only while idle.
// Flow:
//   The voices run one per cycle through a read, shape/multiply, write-back pipe on
//   the phase RAM; the next request waits until the pipe drains, as tready rises
//   again only once the sample is registered.
// Reset: rate_scale returns to its default, all voice phases read as zero.
// Stall: a finished sample waits in the output register; the next request is taken
//   and processed meanwhile, holding only at the final mix until the register frees.
`default_nettype none
module chord_tone_synthesizer #(
    parameter int CHANNELS        = ctsyn_pkg::CHANNELS_DEF,
    parameter int VOICES          = ctsyn_pkg::VOICES_DEF,
    parameter int SINE_TABLE_BITS = ctsyn_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // restart, waveform[2:1], volume[11:3], notes 1..4 at [18:12] [25:19] [32:26] [39:33]
    input  wire logic [ctsyn_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // channel
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // sample
    output logic [ctsyn_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // sample_channel
    output logic                                   m_axis_tuser,
    input  wire logic                              i_cfg_we,
    input  wire logic [ctsyn_pkg::RATE_W-1:0]      i_cfg_wdata
);
    import ctsyn_pkg::*;

    localparam int DEPTH = CHANNELS * VOICES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_MIX   = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [RATE_W-1:0]   r_rate;
    logic [VW-1:0]       r_voice;
    logic                r_ch;
    logic                r_restart;
    logic [1:0]          r_form;
    logic [VOL_W-1:0]    r_vol;
    t_note               r_notes [NOTE_FIELDS];

    logic                r_s1_vld;
    logic [AW-1:0]       r_s1_addr;
    logic [PITCH_W-1:0]  r_s1_pitch;

    logic                r_s2_vld;
    logic [AW-1:0]       r_s2_addr;
    logic                r_s2_act;
    logic [PHASE_W-1:0]  r_s2_phase;
    logic signed [WAVE_W-1:0] r_s2_wave;
    logic [PITCH_W+RATE_HALF-1:0] r_s2_plo;
    logic [PITCH_W+RATE_HALF-1:0] r_s2_phi;

    logic signed [SUM_W-1:0] r_sum;
    logic                r_ovld;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_och;

    logic                w_in_acc;
    logic                w_out_free;
    t_note               w_code;
    logic [AW-1:0]       w_rd_addr;
    logic [PHASE_W-1:0]  w_rd_data;
    logic [PHASE_W-1:0]  w_phase_eff;
    logic signed [WAVE_W-1:0] w_wave;
    logic [PITCH_W+RATE_W-1:0] w_prod;
    logic [PHASE_W-1:0]  w_wr_data;
    logic signed [31:0]  w_mixed;
    logic signed [31:0]  w_shift;
    logic [SAMPLE_W-1:0] w_clamped;
    logic                w_slot;

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_out_free    = !r_ovld || m_axis_tready;

    always_comb begin
        w_code = NOTE_REST;
        for (int v = 0; v < NOTE_FIELDS; v++) begin
            if (int'(r_voice) == v) w_code = r_notes[v];
        end
    end

    assign w_slot    = (CHANNELS > 1) ? r_ch : 1'b0;
    assign w_rd_addr = AW'(int'(w_slot) * VOICES + int'(r_voice));

    ctsyn_phase_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_state == ST_RUN),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_s2_vld),
        .i_wr_addr (r_s2_addr),
        .i_wr_data (w_wr_data)
    );

    assign w_phase_eff = r_restart ? '0 : w_rd_data;

    ctsyn_wave #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_wave (
        .i_form  (r_form),
        .i_phase (w_phase_eff),
        .o_wave  (w_wave)
    );

    assign w_prod    = (PITCH_W+RATE_W)'(r_s2_plo)
                     + ((PITCH_W+RATE_W)'(r_s2_phi) << RATE_HALF);
    assign w_wr_data = r_s2_act ? r_s2_phase + w_prod[24 +: PHASE_W] : r_s2_phase;

    assign w_mixed = 32'(r_sum) * $signed({1'b0, r_vol}) + 32'sd4194304;
    assign w_shift = w_mixed >>> 8;
    always_comb begin
        if (w_shift < -32'sd32768)     w_clamped = 16'h8000;
        else if (w_shift > 32'sd32767) w_clamped = 16'h7fff;
        else                           w_clamped = w_shift[SAMPLE_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_in_acc) n_state = ST_RUN;
            ST_RUN:   if (r_voice == VW'(VOICES - 1)) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_s1_vld && !r_s2_vld) n_state = ST_MIX;
            ST_MIX:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rate   <= RATE_RESET;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_ovld   <= 1'b0;
            r_voice  <= '0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) r_rate <= i_cfg_wdata;
            r_s1_vld <= (r_state == ST_RUN);
            r_s2_vld <= r_s1_vld;
            if (r_state == ST_RUN) r_voice <= r_voice + 1'b1;
            else                   r_voice <= '0;
            if (r_state == ST_MIX && w_out_free) r_ovld <= 1'b1;
            else if (m_axis_tready)              r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ch      <= s_axis_tuser;
            r_restart <= s_axis_tdata[0];
            r_form    <= s_axis_tdata[2:1];
            r_vol     <= (s_axis_tdata[11:3] > VOL_FULL) ? VOL_FULL : s_axis_tdata[11:3];
            r_notes[0] <= s_axis_tdata[18:12];
            r_notes[1] <= s_axis_tdata[25:19];
            r_notes[2] <= s_axis_tdata[32:26];
            r_notes[3] <= s_axis_tdata[39:33];
            r_sum     <= '0;
        end else if (r_s2_vld && r_s2_act) begin
            r_sum <= r_sum + SUM_W'(r_s2_wave);
        end
        r_s1_addr  <= w_rd_addr;
        r_s1_pitch <= note_pitch(w_code);
        r_s2_addr  <= r_s1_addr;
        r_s2_act   <= (r_s1_pitch != '0);
        r_s2_phase <= w_phase_eff;
        r_s2_wave  <= w_wave;
        r_s2_plo   <= r_s1_pitch * r_rate[RATE_HALF-1:0];
        r_s2_phi   <= r_s1_pitch * r_rate[RATE_W-1:RATE_HALF];
        if (r_state == ST_MIX && w_out_free) begin
            r_sample <= w_clamped;
            r_och    <= r_ch;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_sample;
    assign m_axis_tuser  = r_och;

    a_ready_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!r_s1_vld && !r_s2_vld))
        else $error("request taken while voice pipe busy");
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !s_axis_tready)
        else $error("ready high right after acceptance");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled sample dropped or changed");
endmodule
`default_nettype wire
